@@ sv/eqi_pkg.sv @@
// Shared types, codes and defaults of the ERI quartet index iterator.
package eqi_pkg;

    localparam int MAX_SHELL_FUNCS_DEF  = 32;
    localparam int BASIS_INDEX_BITS_DEF = 16;

    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    localparam logic [1:0] MODE_ALL  = 2'd0;
    localparam logic [1:0] MODE_PAIR = 2'd1;
    localparam logic [1:0] MODE_GEN  = 2'd2;
    localparam logic [1:0] MODE_GEN3 = 2'd3;

    typedef struct packed {
        logic        opcode;
        logic [5:0]  size_i;
        logic [5:0]  size_j;
        logic [5:0]  size_k;
        logic [5:0]  size_l;
        logic [15:0] offset_i;
        logic [15:0] offset_j;
        logic [15:0] offset_k;
        logic [15:0] offset_l;
        logic [1:0]  share_mode;
        logic        bra_same;
        logic        ket_same;
    } t_req;

    typedef struct packed {
        logic [15:0] index_p;
        logic [15:0] index_q;
        logic [15:0] index_r;
        logic [15:0] index_s;
        logic [19:0] flat_index;
        logic        finished;
    } t_rsp;

    typedef struct packed {
        logic accept;
        logic stage1;
        logic stage2;
        logic out_load;
    } t_cmd;

endpackage

@@ sv/eqi_req_if.sv @@
// Request channel: valid, ready and one request beat.
interface eqi_req_if;
    logic          valid;
    logic          ready;
    eqi_pkg::t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/eqi_rsp_if.sv @@
// Response channel: valid, ready and one result beat.
interface eqi_rsp_if;
    logic          valid;
    logic          ready;
    eqi_pkg::t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/eqi_ctrl.sv @@
// Controller: sequences accept, the multiply stages and the output register.
module eqi_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_ready,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output eqi_pkg::t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_M1   = 2'd1;
    localparam logic [1:0] S_M2   = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_ovalid;
    logic       n_ovalid;
    logic       w_accept;
    logic       w_load;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_load      = (r_state == S_FIN) && (!r_ovalid || i_out_ready);
    assign o_out_valid = r_ovalid;

    always_comb begin
        o_cmd.accept   = w_accept;
        o_cmd.stage1   = (r_state == S_M1);
        o_cmd.stage2   = (r_state == S_M2);
        o_cmd.out_load = w_load;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_M1;
            end
            S_M1:   n_state = S_M2;
            S_M2:   n_state = S_FIN;
            S_FIN: begin
                if (w_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (w_load) begin
            n_ovalid = 1'b1;
        end else if (i_out_ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    a_accept_m1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_M1)
        else $error("accepted beat did not start the multiply sequence");

    a_m1_m2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_M1 |=> r_state == S_M2)
        else $error("stage one not followed by stage two");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> r_ovalid && r_state == S_IDLE)
        else $error("result load did not raise valid and return to idle");

    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIN && r_ovalid && !i_out_ready |=> r_state == S_FIN)
        else $error("result left while output register full");

endmodule

@@ sv/eqi_dpath.sv @@
// Datapath: counters, limits, index ordering and flat index multiplies.
module eqi_dpath #(
    parameter int MAX_SHELL_FUNCS  = eqi_pkg::MAX_SHELL_FUNCS_DEF,
    parameter int BASIS_INDEX_BITS = eqi_pkg::BASIS_INDEX_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  eqi_pkg::t_cmd i_cmd,
    input  eqi_pkg::t_req i_req,
    output eqi_pkg::t_rsp o_rsp
);

    localparam int CW  = $clog2(MAX_SHELL_FUNCS + 1);
    localparam int BIB = BASIS_INDEX_BITS;
    localparam int FW  = (4 * CW > 20) ? 4 * CW : 20;

    logic [CW-1:0]  r_cnt_i, r_cnt_j, r_cnt_k, r_cnt_l;
    logic [CW-1:0]  n_cnt_i, n_cnt_j, n_cnt_k, n_cnt_l;
    logic [CW-1:0]  r_lim [4];
    logic [CW-1:0]  n_lim [4];
    logic [CW-1:0]  r_size [4];
    logic [CW-1:0]  n_size [4];
    logic [BIB-1:0] r_off [4];
    logic [BIB-1:0] n_off [4];
    logic [1:0]     r_mode, n_mode;
    logic           r_bra, n_bra;
    logic           r_ket, n_ket;
    logic           r_done, n_done;

    logic [2*CW-1:0] r_a;
    logic [3*CW-1:0] r_b;
    logic [BIB-1:0]  r_p, r_q, r_r, r_s;
    logic [BIB-1:0]  r_op, r_oq, r_or, r_os;
    logic [BIB-1:0]  w_p, w_q, w_r, w_s, w_t;
    logic            r_dn1, r_dn2;
    logic [4*CW-1:0] w_flat;
    eqi_pkg::t_rsp   r_rsp;

    function automatic logic [CW-1:0] sat_size(input logic [5:0] sz);
        logic [CW-1:0] res;
        if (sz == 6'd0) begin
            res = CW'(1);
        end else if (int'(sz) > MAX_SHELL_FUNCS) begin
            res = CW'(MAX_SHELL_FUNCS);
        end else begin
            res = CW'(sz);
        end
        return res;
    endfunction

    // load on start, otherwise advance until done
    always_comb begin
        n_cnt_i = r_cnt_i;
        n_cnt_j = r_cnt_j;
        n_cnt_k = r_cnt_k;
        n_cnt_l = r_cnt_l;
        n_lim   = r_lim;
        n_size  = r_size;
        n_off   = r_off;
        n_mode  = r_mode;
        n_bra   = r_bra;
        n_ket   = r_ket;
        n_done  = r_done;
        if (i_req.opcode == eqi_pkg::OP_START) begin
            n_size[0] = sat_size(i_req.size_i);
            n_size[1] = sat_size(i_req.size_j);
            n_size[2] = sat_size(i_req.size_k);
            n_size[3] = sat_size(i_req.size_l);
            n_off[0]  = BIB'(i_req.offset_i);
            n_off[1]  = BIB'(i_req.offset_j);
            n_off[2]  = BIB'(i_req.offset_k);
            n_off[3]  = BIB'(i_req.offset_l);
            n_mode    = (i_req.share_mode == eqi_pkg::MODE_GEN3) ? eqi_pkg::MODE_GEN
                                                                 : i_req.share_mode;
            n_bra     = i_req.bra_same;
            n_ket     = i_req.ket_same;
            n_cnt_i   = '0;
            n_cnt_j   = '0;
            n_cnt_k   = '0;
            n_cnt_l   = '0;
            n_done    = 1'b0;
            n_lim[0]  = n_size[0] - CW'(1);
            case (n_mode)
                eqi_pkg::MODE_ALL: begin
                    n_lim[1] = '0;
                    n_lim[2] = '0;
                    n_lim[3] = '0;
                end
                eqi_pkg::MODE_PAIR: begin
                    n_lim[1] = n_size[1] - CW'(1);
                    n_lim[2] = '0;
                    n_lim[3] = '0;
                end
                default: begin
                    n_lim[1] = n_bra ? '0 : n_size[1] - CW'(1);
                    n_lim[2] = n_size[2] - CW'(1);
                    n_lim[3] = n_ket ? '0 : n_size[3] - CW'(1);
                end
            endcase
        end else if (!r_done) begin
            n_cnt_l = r_cnt_l + CW'(1);
            if (n_cnt_l > r_lim[3]) begin
                n_cnt_k = r_cnt_k + CW'(1);
                n_cnt_l = '0;
                if (n_cnt_k > r_lim[2]) begin
                    n_cnt_k = '0;
                    n_cnt_j = r_cnt_j + CW'(1);
                    if (n_cnt_j > r_lim[1]) begin
                        n_cnt_j = '0;
                        n_cnt_i = r_cnt_i + CW'(1);
                        if (n_cnt_i > r_lim[0]) n_done = 1'b1;
                        if (r_mode == eqi_pkg::MODE_ALL) begin
                            n_lim[1] = n_cnt_i;
                        end else if (r_mode == eqi_pkg::MODE_GEN) begin
                            n_lim[1] = r_bra ? n_cnt_i : r_size[1] - CW'(1);
                        end
                    end
                    if (r_mode != eqi_pkg::MODE_GEN) n_lim[2] = n_cnt_i;
                end
                case (r_mode)
                    eqi_pkg::MODE_ALL:
                        n_lim[3] = (n_cnt_k == n_cnt_i) ? n_cnt_j : n_cnt_k;
                    eqi_pkg::MODE_PAIR:
                        n_lim[3] = (n_cnt_k == n_cnt_i) ? n_cnt_j : r_size[3] - CW'(1);
                    default:
                        n_lim[3] = r_ket ? n_cnt_k : r_size[3] - CW'(1);
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_i <= '0;
            r_cnt_j <= '0;
            r_cnt_k <= '0;
            r_cnt_l <= '0;
            r_mode  <= eqi_pkg::MODE_ALL;
            r_bra   <= 1'b0;
            r_ket   <= 1'b0;
            r_done  <= 1'b0;
            for (int x = 0; x < 4; x++) begin
                r_lim[x]  <= '0;
                r_size[x] <= CW'(1);
                r_off[x]  <= '0;
            end
        end else if (i_cmd.accept) begin
            r_cnt_i <= n_cnt_i;
            r_cnt_j <= n_cnt_j;
            r_cnt_k <= n_cnt_k;
            r_cnt_l <= n_cnt_l;
            r_mode  <= n_mode;
            r_bra   <= n_bra;
            r_ket   <= n_ket;
            r_done  <= n_done;
            r_lim   <= n_lim;
            r_size  <= n_size;
            r_off   <= n_off;
        end
    end

    // canonical ordering of the offset indices, except in mode all
    always_comb begin
        w_p = r_p;
        w_q = r_q;
        w_r = r_r;
        w_s = r_s;
        w_t = '0;
        if (r_mode == eqi_pkg::MODE_PAIR) begin
            if (w_p < w_q) begin
                w_t = w_p; w_p = w_q; w_q = w_t;
                w_t = w_r; w_r = w_s; w_s = w_t;
            end
            if (w_p < w_r) begin
                w_t = w_p; w_p = w_r; w_r = w_t;
                w_t = w_q; w_q = w_s; w_s = w_t;
            end
        end else if (r_mode != eqi_pkg::MODE_ALL) begin
            if (w_p < w_q) begin
                w_t = w_p; w_p = w_q; w_q = w_t;
            end
            if (w_r < w_s) begin
                w_t = w_r; w_r = w_s; w_s = w_t;
            end
            if (w_p < w_r || (w_p == w_r && w_q < w_s)) begin
                w_t = w_p; w_p = w_r; w_r = w_t;
                w_t = w_q; w_q = w_s; w_s = w_t;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.stage1) begin
            r_a   <= (2*CW)'(r_cnt_j) + (2*CW)'(r_size[1]) * (2*CW)'(r_cnt_i);
            r_p   <= r_off[0] + BIB'(r_cnt_i);
            r_q   <= r_off[1] + BIB'(r_cnt_j);
            r_r   <= r_off[2] + BIB'(r_cnt_k);
            r_s   <= r_off[3] + BIB'(r_cnt_l);
            r_dn1 <= r_done;
        end
        if (i_cmd.stage2) begin
            r_b   <= (3*CW)'(r_cnt_k) + (3*CW)'(r_size[2]) * (3*CW)'(r_a);
            r_op  <= w_p;
            r_oq  <= w_q;
            r_or  <= w_r;
            r_os  <= w_s;
            r_dn2 <= r_dn1;
        end
        if (i_cmd.out_load) begin
            if (r_dn2) begin
                r_rsp <= '{index_p: '0, index_q: '0, index_r: '0, index_s: '0,
                           flat_index: '0, finished: 1'b1};
            end else begin
                r_rsp <= '{index_p: 16'(r_op), index_q: 16'(r_oq),
                           index_r: 16'(r_or), index_s: 16'(r_os),
                           flat_index: 20'(FW'(w_flat)), finished: 1'b0};
            end
        end
    end

    assign w_flat = (4*CW)'(r_cnt_l) + (4*CW)'(r_size[3]) * (4*CW)'(r_b);
    assign o_rsp  = r_rsp;

endmodule

@@ sv/eri_quartet_index_iterator.sv @@
// Top level of the ERI symmetry-unique quartet index iterator.
// Each request beat either starts a shell quartet (opcode 0: load sizes,
// offsets and sharing pattern, emit the first quartet) or advances to the
// next symmetry-unique quartet (opcode 1); every beat gives exactly one
// result beat. At the edge that accepts a beat the counters update; the flat
// index then takes three chained multiplies, registered in stage one, in
// stage two and in the output register. The block takes no new beat until
// the previous result is loaded; a new beat is accepted at the edge after
// that load, and waits longer only while the output register still holds an
// untaken result. After the last quartet, every advance returns a result
// with finished set and all indices zero until the next start.
module eri_quartet_index_iterator #(
    parameter int MAX_SHELL_FUNCS  = eqi_pkg::MAX_SHELL_FUNCS_DEF,
    parameter int BASIS_INDEX_BITS = eqi_pkg::BASIS_INDEX_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    eqi_req_if.sink   i_req,
    eqi_rsp_if.source o_rsp
);

    eqi_pkg::t_cmd w_cmd;
    eqi_pkg::t_rsp w_rsp;
    logic          w_in_ready;
    logic          w_out_valid;

    eqi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    eqi_dpath #(
        .MAX_SHELL_FUNCS  (MAX_SHELL_FUNCS),
        .BASIS_INDEX_BITS (BASIS_INDEX_BITS)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_req   (i_req.payload),
        .o_rsp   (w_rsp)
    );

    assign i_req.ready   = w_in_ready;
    assign o_rsp.valid   = w_out_valid;
    assign o_rsp.payload = w_rsp;

endmodule
